// ===== src/frp_pkg.sv =====
// shared types and constants for the framed packet receiver
package frp_pkg;

  localparam logic [7:0]  START_BYTE    = 8'h96;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_GOOD    = 2'd2,
    EV_BAD_SUM = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_ID   = 3'd1,
    PH_CMD  = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_SUM  = 3'd5
  } phase_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] node_id;
    logic [7:0] command;
    logic [7:0] payload_length;
  } out_item_t;

endpackage

// ===== src/frp_parser.sv =====
// frame parser: phase machine, gap counter, frame fields and checksum
module frp_parser #(
  parameter int MAX_PAYLOAD = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  frp_pkg::in_item_t item,
  input  logic [15:0]       gap_timeout_ms,
  output logic              res_valid,
  output frp_pkg::out_item_t res
);

  frp_pkg::phase_t phase, phase_next;
  logic [15:0] gap_count, gap_count_next;
  logic [7:0]  frame_id, frame_id_next;
  logic [7:0]  frame_command, frame_command_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [7:0]  running_sum, running_sum_next;

  logic [7:0]  len_fold [256];
  logic        is_byte;
  logic        timed_out;
  logic [7:0]  b;
  logic [7:0]  count_inc;
  frp_pkg::phase_t cur_phase;
  logic [1:0]  ev;
  logic [7:0]  pb;
  logic [7:0]  pi;

  // constant table for the length fold
  for (genvar i = 0; i < 256; i++) begin : g_fold
    assign len_fold[i] = 8'(i % MAX_PAYLOAD);
  end

  assign b         = item.rx_byte;
  assign is_byte   = accept && (item.operation == frp_pkg::OP_BYTE);
  assign timed_out = gap_count >= gap_timeout_ms;
  assign cur_phase = timed_out ? frp_pkg::PH_HUNT : phase;
  assign count_inc = payload_count + 8'd1;

  // next phase
  always_comb begin
    phase_next = phase;
    if (is_byte) begin
      unique case (cur_phase)
        frp_pkg::PH_HUNT: if (b == frp_pkg::START_BYTE) phase_next = frp_pkg::PH_ID;
                          else phase_next = frp_pkg::PH_HUNT;
        frp_pkg::PH_ID:   phase_next = frp_pkg::PH_CMD;
        frp_pkg::PH_CMD:  phase_next = frp_pkg::PH_LEN;
        frp_pkg::PH_LEN:  phase_next = (len_fold[b] == 8'd0) ? frp_pkg::PH_SUM
                                                             : frp_pkg::PH_DATA;
        frp_pkg::PH_DATA: phase_next = (count_inc >= frame_length) ? frp_pkg::PH_SUM
                                                                   : frp_pkg::PH_DATA;
        frp_pkg::PH_SUM:  phase_next = frp_pkg::PH_HUNT;
        default:          phase_next = frp_pkg::PH_HUNT;
      endcase
    end
  end

  // datapath updates and result
  always_comb begin
    gap_count_next     = gap_count;
    frame_id_next      = frame_id;
    frame_command_next = frame_command;
    frame_length_next  = frame_length;
    payload_count_next = payload_count;
    running_sum_next   = running_sum;
    ev = frp_pkg::EV_NONE;
    pb = 8'd0;
    pi = 8'd0;
    if (accept && item.operation == frp_pkg::OP_TICK) begin
      if (!timed_out) gap_count_next = gap_count + 16'd1;
    end else if (is_byte) begin
      gap_count_next = 16'd0;
      unique case (cur_phase)
        frp_pkg::PH_HUNT: begin
          if (b == frp_pkg::START_BYTE) begin
            running_sum_next   = 8'd0;
            payload_count_next = 8'd0;
          end
        end
        frp_pkg::PH_ID: begin
          frame_id_next    = b;
          running_sum_next = running_sum + b;
        end
        frp_pkg::PH_CMD: begin
          frame_command_next = b;
          frame_length_next  = 8'd0;
          running_sum_next   = running_sum + b;
        end
        frp_pkg::PH_LEN: begin
          frame_length_next  = len_fold[b];
          running_sum_next   = running_sum + b;
          payload_count_next = 8'd0;
        end
        frp_pkg::PH_DATA: begin
          ev = frp_pkg::EV_PAYLOAD;
          pb = b;
          pi = payload_count;
          running_sum_next   = running_sum + b;
          payload_count_next = count_inc;
        end
        frp_pkg::PH_SUM: begin
          ev = (running_sum == b) ? frp_pkg::EV_GOOD : frp_pkg::EV_BAD_SUM;
          payload_count_next = 8'd0;
        end
        default: ;
      endcase
    end
  end

  assign res_valid          = is_byte;
  assign res.event_res      = ev;
  assign res.payload_byte   = pb;
  assign res.payload_index  = pi;
  assign res.node_id        = frame_id_next;
  assign res.command        = frame_command_next;
  assign res.payload_length = frame_length_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= frp_pkg::PH_HUNT;
      gap_count     <= 16'd0;
      frame_id      <= 8'd0;
      frame_command <= 8'd0;
      frame_length  <= 8'd0;
      payload_count <= 8'd0;
      running_sum   <= 8'd0;
    end else begin
      phase         <= phase_next;
      gap_count     <= gap_count_next;
      frame_id      <= frame_id_next;
      frame_command <= frame_command_next;
      frame_length  <= frame_length_next;
      payload_count <= payload_count_next;
      running_sum   <= running_sum_next;
    end
  end

endmodule

// ===== src/frp_out_reg.sv =====
// result register between the parser and the output channel
module frp_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  frp_pkg::out_item_t load_data,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output frp_pkg::out_item_t out_data
);

  logic full;

  assign can_load  = !full || out_ready;
  assign out_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

// ===== src/framed_packet_receiver_core.sv =====
// top level of the framed packet receiver
// Parses frames of start byte 0x96, node id, command, length, payload and an 8-bit
// additive checksum from a stream of transactions that carry either a received byte
// or a millisecond tick. Every byte transaction yields one result (none, payload byte
// with index, packet good, checksum mismatch); a tick yields none. Silence of at
// least gap_timeout_ms ticks before a byte restarts the start-byte hunt. One
// transaction is taken per cycle unless an untaken result blocks in_ready: the parser
// state updates in the accepting cycle and the result appears in the output register
// in the next cycle; a held result lets a new transaction in if it is taken that cycle.
module framed_packet_receiver_core #(
  parameter int MAX_PAYLOAD = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  frp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output frp_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  logic [15:0]        gap_timeout_ms;
  logic               accept;
  logic               res_valid;
  frp_pkg::out_item_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_timeout_ms <= frp_pkg::TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      gap_timeout_ms <= cfg_wr_data;
    end
  end

  assign accept = in_valid && in_ready;

  frp_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .item           (in_data),
    .gap_timeout_ms (gap_timeout_ms),
    .res_valid      (res_valid),
    .res            (res)
  );

  frp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_data (res),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // an accepted byte always leaves a result waiting
  a_byte_gives_result: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.operation == frp_pkg::OP_BYTE) |=> out_valid)
    else $error("byte transaction produced no result");

  // a tick never creates a result
  a_tick_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.operation == frp_pkg::OP_TICK && !out_valid) |=> !out_valid)
    else $error("tick transaction produced a result");

  // payload index stays inside the folded length
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.event_res == frp_pkg::EV_PAYLOAD)
      |-> (out_data.payload_index < out_data.payload_length))
    else $error("payload index beyond frame length");

  // payload fields are zero on non-payload results
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.event_res != frp_pkg::EV_PAYLOAD)
      |-> (out_data.payload_byte == 8'd0 && out_data.payload_index == 8'd0))
    else $error("payload fields set on non-payload result");

endmodule
